// File: hdl/tlvhd_pkg.sv
// Package: types, status codes and helpers for the TLV header stream decoder.
`default_nettype none

package tlvhd_pkg;

   localparam int unsigned BYTE_W  = 8;
   localparam int unsigned TYPE_W  = 32;
   localparam int unsigned LEN_W   = 64;
   localparam int unsigned STAT_W  = 2;
   localparam int unsigned PEND_W  = 4;
   localparam int unsigned RDATA_W = TYPE_W + LEN_W;

   localparam logic [BYTE_W-1:0] MAX_DIRECT = 8'd252;
   localparam logic [BYTE_W-1:0] EXT_TWO    = 8'd253;
   localparam logic [BYTE_W-1:0] EXT_FOUR   = 8'd254;

   typedef enum logic [STAT_W-1:0] {
      STAT_OK       = 2'd0,
      STAT_SHORT    = 2'd1,
      STAT_BIG_TYPE = 2'd2
   } status_type;

   typedef enum logic [3:0] {
      PH_TYPE_FIRST = 4'b0001,
      PH_TYPE_EXT   = 4'b0010,
      PH_LEN_FIRST  = 4'b0100,
      PH_LEN_EXT    = 4'b1000
   } phase_type;

   // extension byte count for a first byte of 253..255
   function automatic logic [PEND_W-1:0] ext_count(input logic [BYTE_W-1:0] b);
      logic [PEND_W-1:0] n;
      if (b == EXT_TWO) begin
         n = 4'd2;
      end else if (b == EXT_FOUR) begin
         n = 4'd4;
      end else begin
         n = 4'd8;
      end
      return n;
   endfunction

endpackage

`default_nettype wire

// File: hdl/tlv_header_stream_decoder.sv
// TLV header stream decoder: one byte per item, one result per header or error.
// Throughput: 1 byte per cycle unless rsp_tready stalls the result register;
// input register, then parser logic into the result register.
// The path from rsp_tready to req_tready is combinational through the two stage enables.
// Reset (synchronous, active high) clears both stages and puts the parser at the first
// type byte of a new header.
`default_nettype none

module tlv_header_stream_decoder
   import tlvhd_pkg::*;
(
   input  wire                      clock,
   input  wire                      reset,
   input  wire                      req_tvalid,
   output logic                     req_tready,
   input  wire  [BYTE_W-1:0]        req_tdata,   // [7:0] data_byte
   input  wire                      req_tlast,   // end_of_buffer
   output logic                     rsp_tvalid,
   input  wire                      rsp_tready,
   output logic [RDATA_W-1:0]       rsp_tdata,   // [31:0] type_number, [95:32] length_value
   output logic [STAT_W-1:0]        rsp_tuser    // [1:0] status
);

   logic                in_valid_ff, in_valid_in;
   logic [BYTE_W-1:0]   in_byte_ff;
   logic                in_last_ff;

   phase_type           phase_ff, phase_in;
   logic [PEND_W-1:0]   pend_ff, pend_in;
   logic [LEN_W-1:0]    acc_ff, acc_in;
   logic [TYPE_W-1:0]   type_ff, type_in;

   logic                out_valid_ff, out_valid_in;
   logic [TYPE_W-1:0]   out_type_ff;
   logic [LEN_W-1:0]    out_len_ff;
   status_type          out_stat_ff;

   logic                advance;
   logic                work;
   logic                emit;
   logic                do_fail;
   status_type          fail_stat;
   logic [TYPE_W-1:0]   res_type;
   logic [LEN_W-1:0]    res_len;
   logic [LEN_W-1:0]    acc_shift;
   logic [PEND_W-1:0]   pend_dec;

   assign advance    = !out_valid_ff || rsp_tready;
   assign req_tready = !in_valid_ff || advance;
   assign work       = in_valid_ff && advance;

   assign acc_shift = {acc_ff[LEN_W-BYTE_W-1:0], in_byte_ff};
   assign pend_dec  = (pend_ff > 4'd1) ? pend_ff - 4'd1 : '0;

   always_comb begin
      phase_in  = phase_ff;
      pend_in   = pend_ff;
      acc_in    = acc_ff;
      type_in   = type_ff;
      emit      = 1'b0;
      do_fail   = 1'b0;
      fail_stat = STAT_SHORT;
      res_type  = type_ff;
      res_len   = '0;
      case (phase_ff)
         PH_TYPE_FIRST: begin
            if (in_byte_ff <= MAX_DIRECT) begin
               type_in  = {{(TYPE_W-BYTE_W){1'b0}}, in_byte_ff};
               phase_in = PH_LEN_FIRST;
            end else begin
               pend_in  = ext_count(in_byte_ff);
               acc_in   = '0;
               phase_in = PH_TYPE_EXT;
            end
            do_fail = in_last_ff;
         end
         PH_TYPE_EXT: begin
            acc_in  = acc_shift;
            pend_in = pend_dec;
            if (pend_dec == '0 && acc_shift[LEN_W-1:TYPE_W] != '0) begin
               do_fail   = 1'b1;
               fail_stat = STAT_BIG_TYPE;
            end else begin
               if (pend_dec == '0) begin
                  type_in  = acc_shift[TYPE_W-1:0];
                  acc_in   = '0;
                  phase_in = PH_LEN_FIRST;
               end
               do_fail = in_last_ff;
            end
         end
         PH_LEN_FIRST: begin
            if (in_byte_ff <= MAX_DIRECT) begin
               emit    = 1'b1;
               res_len = {{(LEN_W-BYTE_W){1'b0}}, in_byte_ff};
            end else begin
               pend_in  = ext_count(in_byte_ff);
               acc_in   = '0;
               phase_in = PH_LEN_EXT;
               do_fail  = in_last_ff;
            end
         end
         PH_LEN_EXT: begin
            acc_in  = acc_shift;
            pend_in = pend_dec;
            if (pend_dec == '0) begin
               emit    = 1'b1;
               res_len = acc_shift;
            end else begin
               do_fail = in_last_ff;
            end
         end
         default: begin
            phase_in = PH_TYPE_FIRST;
         end
      endcase
      // a finished header or an error restarts the parser
      if (emit || do_fail) begin
         phase_in = PH_TYPE_FIRST;
         pend_in  = '0;
         acc_in   = '0;
         type_in  = '0;
      end
      if (do_fail) begin
         emit     = 1'b1;
         res_type = '0;
         res_len  = '0;
      end
   end

   assign in_valid_in  = req_tready ? req_tvalid : in_valid_ff;
   assign out_valid_in = advance ? (work && emit) : out_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         phase_ff     <= PH_TYPE_FIRST;
         pend_ff      <= '0;
         acc_ff       <= '0;
         type_ff      <= '0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         if (work) begin
            phase_ff <= phase_in;
            pend_ff  <= pend_in;
            acc_ff   <= acc_in;
            type_ff  <= type_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready) begin
         in_byte_ff <= req_tdata;
         in_last_ff <= req_tlast;
      end
      if (work && emit) begin
         out_type_ff <= res_type;
         out_len_ff  <= res_len;
         out_stat_ff <= do_fail ? fail_stat : STAT_OK;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {out_len_ff, out_type_ff};
   assign rsp_tuser  = out_stat_ff;

   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser != STAT_OK) |-> (rsp_tdata == '0))
      else $error("error item carries nonzero data");

   a_stat_code: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tuser == STAT_OK || rsp_tuser == STAT_SHORT ||
                      rsp_tuser == STAT_BIG_TYPE))
      else $error("undefined status code");

   a_pend_ext: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_TYPE_EXT || phase_ff == PH_LEN_EXT) |-> (pend_ff != '0))
      else $error("extension phase with no bytes pending");

   a_pend_first: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_TYPE_FIRST || phase_ff == PH_LEN_FIRST) |-> (pend_ff == '0))
      else $error("bytes pending outside extension phase");

   a_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=> (rsp_tvalid && $stable(rsp_tdata)))
      else $error("stalled result changed");

endmodule

`default_nettype wire
